// File: rtl/core/nbg_pkg.sv
// Shared widths, constants and types of the n-body acceleration block.
// No dependencies.
`default_nettype none
package nbg_pkg;
    localparam int MAX_BODIES_DEF = 1024;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam logic [CNT_W-1:0] COUNT_RST = 11'd1024;
    localparam int POS_W  = 32;
    localparam int D_W    = 33;
    localparam int D2_W   = 66;
    localparam int ROOT_W = 34;
    localparam int DEN_W  = 100;
    localparam int NUM_W  = 97;
    localparam int Q_W    = 48;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 68;
    localparam int ACC_W  = 64;
    localparam logic [Q_W-1:0] TERM_LIMIT = 48'h4000_0000_0000;

    typedef struct packed {
        logic           done;
        logic           over;
        logic [Q_W-1:0] quot;
    } div_res_t;
endpackage
`default_nettype wire

// File: rtl/core/nbg_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on nbg_pkg.
`default_nettype none
module nbg_sqrt import nbg_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [D2_W-1:0]   radicand,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);
    localparam int SW = $clog2(ROOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [SW-1:0]     step_reg;
    logic [2*ROOT_W-1:0] rad_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;

    assign rem_sh = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= {{(2*ROOT_W-D2_W){1'b0}}, radicand};
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= SW'(ROOT_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= {rad_reg[2*ROOT_W-3:0], 2'b00};
                rem_reg  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// File: rtl/core/nbg_div.sv
// Restoring divider, one quotient bit per cycle; flags quotients beyond its range.
// Depends on nbg_pkg.
`default_nettype none
module nbg_div import nbg_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output div_res_t              res
);
    localparam int SW = $clog2(Q_W);

    logic             busy_reg;
    logic             done_reg;
    logic             over_reg;
    logic [SW-1:0]    step_reg;
    logic [DEN_W:0]   rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   head;
    logic             ge;

    assign head  = {{(DEN_W+1-(NUM_W-Q_W)){1'b0}}, num[NUM_W-1:Q_W]};
    assign trial = {rem_reg[DEN_W-1:0], low_reg[Q_W-1]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // quotient too wide for the quotient register: report overflow at once
                if (head >= {1'b0, den}) begin
                    over_reg <= 1'b1;
                    done_reg <= 1'b1;
                end else begin
                    over_reg <= 1'b0;
                    rem_reg  <= head;
                    low_reg  <= num[Q_W-1:0];
                    quot_reg <= '0;
                    step_reg <= SW'(Q_W - 1);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg  <= ge ? (trial - {1'b0, den}) : trial;
                low_reg  <= {low_reg[Q_W-2:0], 1'b0};
                quot_reg <= {quot_reg[Q_W-2:0], ge};
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.over = over_reg;
    assign res.quot = quot_reg;
endmodule
`default_nettype wire

// File: rtl/core/nbody_gravity_accel.sv
// Top level: body store memories, pair sequencer, shared multiplier, result register.
// Depends on nbg_pkg, nbg_sqrt, nbg_div.
//
// Usage:
//  - Input channel s_*: mode 0 stores mass and position at body_index, no result.
//    Mode 1 queries body_index and gives one transfer on the m_* channel.
//  - body_count (cfg_wr_en/cfg_wr_data) sets how many stored bodies enter a sum.
//  - A store subtracts MAX_BODIES from the index until it is in range, then writes that slot.
//  - A query walks bodies 0..n-1 one at a time through a shared 34x34
//    multiplier, a 34-step square root and three 48-step divisions; the
//    iterative divider takes most of the time spent on each body.
//  - s_ready is high only between items; the result register lets the next
//    item in while a finished result still waits on m_ready.
//  - A query that finishes while the previous result is still held waits
//    until that result transfers.
//  - Reset clears the control state and sets body_count to 1024; memory
//    contents are undefined until written.
`default_nettype none
module nbody_gravity_accel import nbg_pkg::*; #(
    parameter int MAX_BODIES = MAX_BODIES_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CNT_W-1:0]        cfg_wr_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_mode,
    input  wire logic [IDX_W-1:0]        s_body_index,
    input  wire logic [POS_W-1:0]        s_mass,
    input  wire logic signed [POS_W-1:0] s_pos_x,
    input  wire logic signed [POS_W-1:0] s_pos_y,
    input  wire logic signed [POS_W-1:0] s_pos_z,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [IDX_W-1:0]             m_query_index,
    output logic signed [POS_W-1:0]      m_acc_x,
    output logic signed [POS_W-1:0]      m_acc_y,
    output logic signed [POS_W-1:0]      m_acc_z,
    output logic                         m_saturated,
    output logic                         m_coincident
);
    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = AW + 1;
    localparam int RW = (AW > IDX_W) ? AW : IDX_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_REDUCE, ST_SELF, ST_NEXT, ST_FETCH,
        ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_ROOT,
        ST_DEN0, ST_DEN1, ST_DEN2, ST_NUM0, ST_NUM1, ST_DIV, ST_DONE
    } state_t;

    state_t state_reg;

    // body store
    logic [POS_W-1:0] mass_mem [MAX_BODIES];
    logic [POS_W-1:0] x_mem    [MAX_BODIES];
    logic [POS_W-1:0] y_mem    [MAX_BODIES];
    logic [POS_W-1:0] z_mem    [MAX_BODIES];
    logic [POS_W-1:0] rd_m_reg, rd_x_reg, rd_y_reg, rd_z_reg;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;

    logic [CNT_W-1:0] count_reg;
    logic             mode_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [RW-1:0]    red_reg;
    logic [POS_W-1:0] in_m_reg, in_x_reg, in_y_reg, in_z_reg;
    logic [CW-1:0]    n_reg, j_reg;
    logic [1:0]       k_reg;
    logic signed [D_W-1:0] xi_reg, yi_reg, zi_reg;
    logic [D_W-1:0]   ad_reg [3];
    logic [2:0]       neg_reg;
    logic [POS_W-1:0] mj_reg;
    logic [D2_W-1:0]  d2_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [DEN_W-1:0] den_reg;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic             sat_reg, coin_reg;
    logic             m_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [POS_W-1:0] out_acc_reg [3];
    logic             out_sat_reg, out_coin_reg;

    logic [MUL_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] prod_reg;
    logic [D2_W-1:0]  d2_sum_next;
    logic             red_over;
    logic [AW-1:0]    slot;
    logic             sq_start, sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic             dv_start;
    div_res_t         dv_res;
    logic             term_big;
    logic [Q_W-1:0]   term_mag;
    logic signed [ACC_W-1:0] term;
    logic signed [D_W-1:0] dx, dy, dz;
    logic [POS_W-1:0] clip_val [3];
    logic [2:0]       clip_hit;

    assign red_over    = 32'(red_reg) >= 32'(MAX_BODIES);
    assign slot        = red_reg[AW-1:0];
    assign d2_sum_next = d2_reg + prod_reg[D2_W-1:0];

    assign dx = $signed({rd_x_reg[POS_W-1], rd_x_reg}) - xi_reg;
    assign dy = $signed({rd_y_reg[POS_W-1], rd_y_reg}) - yi_reg;
    assign dz = $signed({rd_z_reg[POS_W-1], rd_z_reg}) - zi_reg;

    // memory access control
    always_comb begin
        mem_we    = (state_reg == ST_REDUCE) && !red_over && !mode_reg;
        mem_waddr = slot;
        mem_re    = 1'b0;
        mem_raddr = slot;
        if (state_reg == ST_REDUCE && !red_over && mode_reg) begin
            mem_re = 1'b1;
        end else if (state_reg == ST_NEXT && j_reg != n_reg && j_reg[AW-1:0] != slot) begin
            mem_re    = 1'b1;
            mem_raddr = j_reg[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mass_mem[mem_waddr] <= in_m_reg;
            x_mem[mem_waddr]    <= in_x_reg;
            y_mem[mem_waddr]    <= in_y_reg;
            z_mem[mem_waddr]    <= in_z_reg;
        end
        if (mem_re) begin
            rd_m_reg <= mass_mem[mem_raddr];
            rd_x_reg <= x_mem[mem_raddr];
            rd_y_reg <= y_mem[mem_raddr];
            rd_z_reg <= z_mem[mem_raddr];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ0: begin
                mul_a = MUL_W'(ad_reg[0]);
                mul_b = MUL_W'(ad_reg[0]);
            end
            ST_SQ1: begin
                mul_a = MUL_W'(ad_reg[1]);
                mul_b = MUL_W'(ad_reg[1]);
            end
            ST_SQ2: begin
                mul_a = MUL_W'(ad_reg[2]);
                mul_b = MUL_W'(ad_reg[2]);
            end
            ST_DEN0: begin
                mul_a = MUL_W'(d2_reg[32:0]);
                mul_b = root_reg;
            end
            ST_DEN1: begin
                mul_a = MUL_W'(d2_reg[D2_W-1:33]);
                mul_b = root_reg;
            end
            ST_NUM0: begin
                mul_a = MUL_W'(mj_reg);
                mul_b = MUL_W'(ad_reg[k_reg]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign sq_start = (state_reg == ST_SQ3) && (d2_sum_next != '0);
    assign dv_start = (state_reg == ST_NUM1);

    nbg_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (d2_sum_next),
        .done     (sq_done),
        .root     (sq_root)
    );

    nbg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start),
        .num     ({prod_reg[64:0], 32'b0}),
        .den     (den_reg),
        .res     (dv_res)
    );

    assign term_big = dv_res.over || (dv_res.quot > TERM_LIMIT);
    assign term_mag = term_big ? TERM_LIMIT : dv_res.quot;
    assign term     = neg_reg[k_reg] ? -$signed(ACC_W'(term_mag)) : $signed(ACC_W'(term_mag));

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            clip_hit[c] = 1'b1;
            if (acc_reg[c] > 64'sd2147483647) begin
                clip_val[c] = 32'h7fff_ffff;
            end else if (acc_reg[c] < -64'sd2147483648) begin
                clip_val[c] = 32'h8000_0000;
            end else begin
                clip_val[c] = acc_reg[c][POS_W-1:0];
                clip_hit[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= COUNT_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            // in ST_DONE the result register is reloaded below instead
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg  <= s_mode;
                        idx_reg   <= s_body_index;
                        red_reg   <= RW'(s_body_index);
                        in_m_reg  <= s_mass;
                        in_x_reg  <= s_pos_x;
                        in_y_reg  <= s_pos_y;
                        in_z_reg  <= s_pos_z;
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    n_reg <= (32'(count_reg) > 32'(MAX_BODIES)) ? CW'(MAX_BODIES)
                                                                : CW'(count_reg);
                    if (red_over) begin
                        red_reg <= red_reg - RW'(MAX_BODIES);
                    end else if (!mode_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_SELF;
                    end
                end
                ST_SELF: begin
                    xi_reg <= $signed({rd_x_reg[POS_W-1], rd_x_reg});
                    yi_reg <= $signed({rd_y_reg[POS_W-1], rd_y_reg});
                    zi_reg <= $signed({rd_z_reg[POS_W-1], rd_z_reg});
                    for (int c = 0; c < 3; c++) begin
                        acc_reg[c] <= '0;
                    end
                    sat_reg   <= 1'b0;
                    coin_reg  <= 1'b0;
                    j_reg     <= '0;
                    state_reg <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (j_reg == n_reg) begin
                        state_reg <= ST_DONE;
                    end else if (j_reg[AW-1:0] == slot) begin
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    ad_reg[0]  <= dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
                    ad_reg[1]  <= dy[D_W-1] ? D_W'(-dy) : D_W'(dy);
                    ad_reg[2]  <= dz[D_W-1] ? D_W'(-dz) : D_W'(dz);
                    neg_reg    <= {dz[D_W-1], dy[D_W-1], dx[D_W-1]};
                    mj_reg     <= rd_m_reg;
                    state_reg  <= ST_SQ0;
                end
                ST_SQ0: state_reg <= ST_SQ1;
                ST_SQ1: begin
                    d2_reg    <= prod_reg[D2_W-1:0];
                    state_reg <= ST_SQ2;
                end
                ST_SQ2: begin
                    d2_reg    <= d2_sum_next;
                    state_reg <= ST_SQ3;
                end
                ST_SQ3: begin
                    d2_reg <= d2_sum_next;
                    if (d2_sum_next == '0) begin
                        // coincident body: skip it
                        coin_reg  <= 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_NEXT;
                    end else begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sq_done) begin
                        root_reg  <= sq_root;
                        state_reg <= ST_DEN0;
                    end
                end
                ST_DEN0: state_reg <= ST_DEN1;
                ST_DEN1: begin
                    den_reg   <= DEN_W'(prod_reg);
                    state_reg <= ST_DEN2;
                end
                ST_DEN2: begin
                    den_reg   <= den_reg + {prod_reg[DEN_W-34:0], 33'b0};
                    k_reg     <= '0;
                    state_reg <= ST_NUM0;
                end
                ST_NUM0: state_reg <= ST_NUM1;
                ST_NUM1: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (dv_res.done) begin
                        acc_reg[k_reg] <= acc_reg[k_reg] + term;
                        if (term_big) begin
                            sat_reg <= 1'b1;
                        end
                        if (k_reg == 2'd2) begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_NEXT;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_NUM0;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        out_idx_reg  <= idx_reg;
                        for (int c = 0; c < 3; c++) begin
                            out_acc_reg[c] <= clip_val[c];
                        end
                        out_sat_reg  <= sat_reg || (clip_hit != '0);
                        out_coin_reg <= coin_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_query_index = out_idx_reg;
    assign m_acc_x       = out_acc_reg[0];
    assign m_acc_y       = out_acc_reg[1];
    assign m_acc_z       = out_acc_reg[2];
    assign m_saturated   = out_sat_reg;
    assign m_coincident  = out_coin_reg;
endmodule
`default_nettype wire

// File: rtl/core/nbg_checker.sv
// Port-level checks for nbody_gravity_accel, attached by bind.
// Depends on nbg_pkg.
`default_nettype none
module nbg_checker import nbg_pkg::*; (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire logic                    s_mode,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic [IDX_W-1:0]        m_query_index,
    input wire logic signed [POS_W-1:0] m_acc_x,
    input wire logic signed [POS_W-1:0] m_acc_y,
    input wire logic signed [POS_W-1:0] m_acc_z,
    input wire logic                    m_saturated,
    input wire logic                    m_coincident
);
    // an accepted item always drops s_ready in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after a transfer");

    // a store never produces a result on its own
    a_store_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_mode && !m_valid |=> !m_valid)
        else $error("result raised by a store");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_query_index) && $stable(m_acc_x)
            && $stable(m_acc_y) && $stable(m_acc_z) && $stable(m_saturated)
            && $stable(m_coincident))
        else $error("pending result changed");
endmodule

bind nbody_gravity_accel nbg_checker u_nbg_checker (.*);
`default_nettype wire
